// File: design/rbad_pkg.sv
package rbad_pkg;

  localparam int OUT_COLS = 1280;
  localparam int OUT_ROWS = 720;
  localparam int COL_W    = $clog2(OUT_COLS);
  localparam int ROW_W    = $clog2(OUT_ROWS);

  localparam int PIX_W  = 8;
  localparam int HSUM_W = 10;
  localparam int CSUM_W = 11;
  localparam int BSUM_W = 12;

  localparam int              DIV9_MUL_W = 13;
  localparam int              DIV9_PROD_W = BSUM_W + DIV9_MUL_W;
  localparam int              DIV9_SH    = 16;
  localparam [DIV9_MUL_W-1:0] DIV9_MUL   = 13'd7282;

  typedef enum logic [1:0] {
    PH_0,
    PH_1,
    PH_2
  } col_phase_t;

  typedef enum logic [1:0] {
    ROW_INIT,
    ROW_ACC,
    ROW_EMIT
  } row_phase_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [HSUM_W-1:0] red;
    logic [HSUM_W-1:0] green;
    logic [HSUM_W-1:0] blue;
  } hsum_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    logic             pass;
    pix_t             pix;
    hsum_t            hsum;
    row_phase_t       row_ph;
    logic [COL_W-1:0] col;
    logic             last;
  } s1_t;

  function automatic logic [PIX_W-1:0] div9(input logic [BSUM_W-1:0] x);
    logic [DIV9_PROD_W-1:0] prod;
    prod = DIV9_PROD_W'(x) * DIV9_PROD_W'(DIV9_MUL);
    return prod[DIV9_SH +: PIX_W];
  endfunction

endpackage

// File: design/rbad_if.sv
interface rbad_pix_if;
  import rbad_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  logic             frame_start;
  modport source (output valid, in_red, in_green, in_blue, frame_start, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, frame_start, output ready);
endinterface

interface rbad_res_if;
  import rbad_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface rbad_cfg_if;
  logic valid;
  logic ready;
  logic downscale_on;
  modport source (output valid, downscale_on, input ready);
  modport sink   (input valid, downscale_on, output ready);
endinterface

// File: design/rbad_colsum_store.sv
module rbad_colsum_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [rbad_pkg::COL_W-1:0] rd_addr,
  output rbad_pkg::csum_t           rd_data,
  input  logic                      wr_en,
  input  logic [rbad_pkg::COL_W-1:0] wr_addr,
  input  rbad_pkg::csum_t           wr_data
);
  import rbad_pkg::*;

  csum_t mem [OUT_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/rgb_block_average_downscale_3x.sv
// RGB 3x3 block-average downscaler.
// in_pix: one 8-bit RGB pixel per beat in raster order; frame_start on a
// frame's first pixel clears the position counters and drops any block
// in progress.
// out_res: in downscale mode one beat per 3x3 block, each channel the floor
// of the block sum over nine; in pass-through mode one beat per pixel, the
// pixel unchanged. frame_end marks the frame's last output beat.
// cfg_wr: downscale_on (1 averages, 0 passes through); always ready. A write
// clears the position counters; write only while no beat is in flight.
// Throughput: one pixel per cycle while not stalled. A result passes through
// the stage-one register, then the output register. Partial column sums live
// in a one-read, one-write line store of OUT_COLS entries with a registered read.
// Reset: downscale mode, counters at frame origin; the line store is not
// cleared, every entry is written on the first block row before it is read.
// Stall: a full output register that is not taken holds the result stage,
// and in_pix.ready falls until it drains.
module rgb_block_average_downscale_3x (
  input logic       clk,
  input logic       rst_n,
  rbad_cfg_if.sink  cfg_wr,
  rbad_pix_if.sink  in_pix,
  rbad_res_if.source out_res
);
  import rbad_pkg::*;

  logic             mode_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  col_phase_t       cph_r, cph_nxt;
  row_phase_t       rph_r, rph_nxt;
  hsum_t            hsum_r, hsum_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  s1_t              s1_r, s1_nxt;
  csum_t            q;

  logic             out_valid_r;
  pix_t             out_pix_r, out_pix_nxt;
  logic             out_last_r;

  logic             accept, cfg_accept;
  logic [COL_W-1:0] col_e;
  logic [ROW_W-1:0] row_e;
  col_phase_t       cph_e;
  row_phase_t       rph_e;
  logic             col_end, row_end;
  pix_t             px;

  logic             rd_en, wr_en, produce, stall, s1_go;
  csum_t            wr_data;
  logic [BSUM_W-1:0] bs_red, bs_green, bs_blue;

  assign cfg_wr.ready = 1'b1;
  assign cfg_accept   = cfg_wr.valid && cfg_wr.ready;
  assign in_pix.ready = !stall;
  assign accept       = in_pix.valid && in_pix.ready;

  assign px.red   = in_pix.in_red;
  assign px.green = in_pix.in_green;
  assign px.blue  = in_pix.in_blue;

  assign col_e = in_pix.frame_start ? '0 : col_r;
  assign row_e = in_pix.frame_start ? '0 : row_r;
  assign cph_e = in_pix.frame_start ? PH_0 : cph_r;
  assign rph_e = in_pix.frame_start ? ROW_INIT : rph_r;

  assign col_end = (col_e == COL_W'(OUT_COLS - 1));
  assign row_end = (row_e == ROW_W'(OUT_ROWS - 1));

  always_comb begin
    if (cph_e == PH_0) begin
      hsum_nxt.red   = HSUM_W'(px.red);
      hsum_nxt.green = HSUM_W'(px.green);
      hsum_nxt.blue  = HSUM_W'(px.blue);
    end else begin
      hsum_nxt.red   = hsum_r.red   + HSUM_W'(px.red);
      hsum_nxt.green = hsum_r.green + HSUM_W'(px.green);
      hsum_nxt.blue  = hsum_r.blue  + HSUM_W'(px.blue);
    end
  end

  // advance position counters
  always_comb begin
    col_nxt = col_e;
    row_nxt = row_e;
    cph_nxt = cph_e;
    rph_nxt = rph_e;
    if (!mode_r) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_e + ROW_W'(1);
      end else begin
        col_nxt = col_e + COL_W'(1);
      end
    end else begin
      case (cph_e)
        PH_0:    cph_nxt = PH_1;
        PH_1:    cph_nxt = PH_2;
        default: begin
          cph_nxt = PH_0;
          if (col_end) begin
            col_nxt = '0;
            case (rph_e)
              ROW_INIT: rph_nxt = ROW_ACC;
              ROW_ACC:  rph_nxt = ROW_EMIT;
              default: begin
                rph_nxt = ROW_INIT;
                row_nxt = row_end ? '0 : row_e + ROW_W'(1);
              end
            endcase
          end else begin
            col_nxt = col_e + COL_W'(1);
          end
        end
      endcase
    end
  end

  assign rd_en = accept && mode_r && (cph_e == PH_2);

  always_comb begin
    s1_nxt.pass   = !mode_r;
    s1_nxt.pix    = px;
    s1_nxt.hsum   = hsum_nxt;
    s1_nxt.row_ph = rph_e;
    s1_nxt.col    = col_e;
    s1_nxt.last   = col_end && row_end;
  end

  // result stage: write back partial sums or form the output beat
  assign bs_red   = BSUM_W'(q.red)   + BSUM_W'(s1_r.hsum.red);
  assign bs_green = BSUM_W'(q.green) + BSUM_W'(s1_r.hsum.green);
  assign bs_blue  = BSUM_W'(q.blue)  + BSUM_W'(s1_r.hsum.blue);

  assign produce = s1_valid_r && (s1_r.pass || (s1_r.row_ph == ROW_EMIT));
  assign stall   = produce && out_valid_r && !out_res.ready;
  assign s1_go   = produce && !stall;
  assign wr_en   = s1_valid_r && !s1_r.pass && (s1_r.row_ph != ROW_EMIT);

  always_comb begin
    if (s1_r.row_ph == ROW_INIT) begin
      wr_data.red   = CSUM_W'(s1_r.hsum.red);
      wr_data.green = CSUM_W'(s1_r.hsum.green);
      wr_data.blue  = CSUM_W'(s1_r.hsum.blue);
    end else begin
      wr_data.red   = bs_red[CSUM_W-1:0];
      wr_data.green = bs_green[CSUM_W-1:0];
      wr_data.blue  = bs_blue[CSUM_W-1:0];
    end
  end

  always_comb begin
    if (s1_r.pass) begin
      out_pix_nxt = s1_r.pix;
    end else begin
      out_pix_nxt.red   = div9(bs_red);
      out_pix_nxt.green = div9(bs_green);
      out_pix_nxt.blue  = div9(bs_blue);
    end
  end

  assign s1_valid_nxt = stall ? 1'b1 : (accept && (!mode_r || (cph_e == PH_2)));

  rbad_colsum_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (col_e),
    .rd_data (q),
    .wr_en   (wr_en),
    .wr_addr (s1_r.col),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      col_r  <= '0;
      row_r  <= '0;
      cph_r  <= PH_0;
      rph_r  <= ROW_INIT;
      hsum_r <= '0;
    end else if (cfg_accept) begin
      mode_r <= cfg_wr.downscale_on;
      col_r  <= '0;
      row_r  <= '0;
      cph_r  <= PH_0;
      rph_r  <= ROW_INIT;
      hsum_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cph_r  <= cph_nxt;
      rph_r  <= rph_nxt;
      hsum_r <= hsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_go) begin
      out_pix_r  <= out_pix_nxt;
      out_last_r <= s1_r.last;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.out_red   = out_pix_r.red;
  assign out_res.out_green = out_pix_r.green;
  assign out_res.out_blue  = out_pix_r.blue;
  assign out_res.frame_end = out_last_r;

endmodule

// File: design/rbad_checker.sv
module rbad_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [23:0] out_data
);

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result beat dropped under stall");

  property p_out_stable;
    @(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> $stable(out_data);
  endproperty
  a_out_stable: assert property (p_out_stable) else $error("result changed under stall");

  property p_rise_after_beat;
    @(posedge clk) disable iff (!rst_n)
      $rose(out_valid) |-> $past(in_valid && in_ready, 2);
  endproperty
  a_rise_after_beat: assert property (p_rise_after_beat)
    else $error("result without input beat two cycles earlier");

  property p_ready_only_on_stall;
    @(posedge clk) disable iff (!rst_n)
      !in_ready |-> out_valid && !out_ready;
  endproperty
  a_ready_only_on_stall: assert property (p_ready_only_on_stall)
    else $error("input held off without output stall");

endmodule

bind rgb_block_average_downscale_3x rbad_checker u_rbad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_data  ({out_res.out_red, out_res.out_green, out_res.out_blue})
);

// File: dv/rgb_block_average_downscale_3x_tb.sv
`timescale 1ns / 1ps

module rgb_block_average_downscale_3x_tb;
  import rbad_pkg::*;

  localparam int          SETTLE_CYCLES = 8;
  localparam int          BLOCK_AREA    = 9;
  localparam int          SRC_COLS      = 3 * OUT_COLS;
  localparam int unsigned CYCLE_LIMIT   = 200_000;

  typedef struct packed {
    pix_t pix;
    logic frame_end;
  } res_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  rbad_cfg_if cfg_bus ();
  rbad_pix_if pix_bus ();
  rbad_res_if res_bus ();

  rgb_block_average_downscale_3x DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_bus.sink),
    .in_pix  (pix_bus.sink),
    .out_res (res_bus.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic             ds_mode;
  logic [11:0]      src_col;
  col_phase_t       col_ph;
  row_phase_t       row_ph;
  logic [ROW_W-1:0] out_row;
  hsum_t            h_acc;
  csum_t            col_acc [OUT_COLS];

  res_beat_t   expected_pixels [$];
  int          mismatch_cnt  = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off_req  = 0;
  int          hold_cnt      = 0;
  int unsigned cyc_cnt       = 0;

  function automatic void clear_position();
    src_col = '0;
    col_ph  = PH_0;
    row_ph  = ROW_INIT;
    out_row = '0;
    h_acc   = '0;
  endfunction

  function automatic void block_average_step(input pix_t p, input logic fs);
    res_beat_t        beat;
    logic [COL_W-1:0] oc;
    logic [BSUM_W-1:0] bs_r, bs_g, bs_b;
    if (fs) clear_position();
    if (!ds_mode) begin
      beat.pix       = p;
      beat.frame_end = (src_col == OUT_COLS - 1) && (out_row == OUT_ROWS - 1);
      expected_pixels.push_back(beat);
      if (src_col == OUT_COLS - 1) begin
        src_col = '0;
        out_row = (out_row == OUT_ROWS - 1) ? '0 : out_row + 1'b1;
      end else begin
        src_col = src_col + 1'b1;
      end
    end else begin
      if (col_ph == PH_0) begin
        h_acc.red   = HSUM_W'(p.red);
        h_acc.green = HSUM_W'(p.green);
        h_acc.blue  = HSUM_W'(p.blue);
      end else begin
        h_acc.red   = h_acc.red + p.red;
        h_acc.green = h_acc.green + p.green;
        h_acc.blue  = h_acc.blue + p.blue;
      end
      if (col_ph == PH_2) begin
        oc = COL_W'(src_col / 3);
        case (row_ph)
          ROW_INIT: begin
            col_acc[oc].red   = CSUM_W'(h_acc.red);
            col_acc[oc].green = CSUM_W'(h_acc.green);
            col_acc[oc].blue  = CSUM_W'(h_acc.blue);
          end
          ROW_ACC: begin
            col_acc[oc].red   = col_acc[oc].red + h_acc.red;
            col_acc[oc].green = col_acc[oc].green + h_acc.green;
            col_acc[oc].blue  = col_acc[oc].blue + h_acc.blue;
          end
          default: begin
            bs_r = BSUM_W'(col_acc[oc].red) + BSUM_W'(h_acc.red);
            bs_g = BSUM_W'(col_acc[oc].green) + BSUM_W'(h_acc.green);
            bs_b = BSUM_W'(col_acc[oc].blue) + BSUM_W'(h_acc.blue);
            beat.pix.red   = PIX_W'(bs_r / BLOCK_AREA);
            beat.pix.green = PIX_W'(bs_g / BLOCK_AREA);
            beat.pix.blue  = PIX_W'(bs_b / BLOCK_AREA);
            beat.frame_end = (oc == OUT_COLS - 1) && (out_row == OUT_ROWS - 1);
            expected_pixels.push_back(beat);
          end
        endcase
      end
      col_ph = (col_ph == PH_2) ? PH_0 : col_phase_t'(col_ph + 1'b1);
      if (src_col == SRC_COLS - 1) begin
        src_col = '0;
        col_ph  = PH_0;
        if (row_ph == ROW_EMIT) begin
          row_ph  = ROW_INIT;
          out_row = (out_row == OUT_ROWS - 1) ? '0 : out_row + 1'b1;
        end else begin
          row_ph = row_phase_t'(row_ph + 1'b1);
        end
      end else begin
        src_col = src_col + 1'b1;
      end
    end
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  function automatic logic [PIX_W-1:0] pattern_px(input int oc, input int rp, input int cp);
    case (oc % 6)
      0: return 8'd255;
      1: return 8'd0;
      2: return (rp == 0 && cp == 0) ? 8'd8 : 8'd0;
      3: return (rp == 2 && cp == 2) ? 8'd9 : 8'd0;
      4: return (rp == 1 && cp == 1) ? 8'd254 : 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                      input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic send_pixel(input pix_t p, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.in_red      <= p.red;
    pix_bus.in_green    <= p.green;
    pix_bus.in_blue     <= p.blue;
    pix_bus.frame_start <= fs;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    block_average_step(p, fs);
  endtask

  task automatic wait_drained();
    pix_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic on);
    cfg_bus.valid        <= 1'b1;
    cfg_bus.downscale_on <= on;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    ds_mode = on;
    clear_position();
  endtask

  // three source rows, i.e. one full row of output blocks
  task automatic send_band(input logic patterned, input logic lead_start);
    pix_t p;
    for (int rp = 0; rp < 3; rp++) begin
      for (int x = 0; x < SRC_COLS; x++) begin
        if (patterned) begin
          p.red   = pattern_px(x / 3, rp, x % 3);
          p.green = pattern_px(x / 3 + 1, rp, x % 3);
          p.blue  = pattern_px(x / 3 + 2, rp, x % 3);
        end else begin
          p = rand_pixel();
        end
        send_pixel(p, lead_start && rp == 0 && x == 0);
      end
    end
  endtask

  task automatic test_reset_default();
    send_pixel(24'h0000ff, 1'b1);
    repeat (4) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
  endtask

  task automatic test_passthrough_extremes();
    write_mode(1'b0);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'hff0000, 1'b0);
    send_pixel(24'h00ff00, 1'b0);
    send_pixel(24'h0000ff, 1'b0);
    for (int i = 0; i < 8; i++)
      send_pixel({8'(1 << i), 8'(1 << (7 - i)), ~8'(1 << i)}, 1'b0);
    send_pixel(24'haa55aa, 1'b0);
    // early frame start mid-line
    send_pixel(24'h123456, 1'b1);
    send_pixel(24'h55aa55, 1'b0);
    wait_idle();
  endtask

  task automatic test_block_extremes();
    write_mode(1'b1);
    send_band(1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_downscale_random(input int n_runs);
    int run_len;
    write_mode(1'b1);
    for (int r = 0; r < n_runs; r++) begin
      run_len = $urandom_range(60, 1);
      send_pixel(rand_pixel(), 1'b1);
      repeat (run_len) send_pixel(rand_pixel(), $urandom_range(19) == 0);
    end
    wait_idle();
  endtask

  task automatic test_mode_switch();
    write_mode(1'b0);
    send_pixel(rand_pixel(), 1'b1);
    repeat (6) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
    write_mode(1'b1);
    repeat (5) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
    write_mode(1'b1);
    repeat (4) send_pixel(rand_pixel(), 1'b1);
    repeat (2) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
    write_mode(1'b0);
    repeat (4) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_mode(1'b0);
    hold_off_req = 300;
    send_pixel(rand_pixel(), 1'b1);
    repeat (200) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
  endtask

  task automatic test_drain_pause();
    write_mode(1'b0);
    repeat (40) send_pixel(rand_pixel(), 1'b0);
    wait_drained();
    repeat (40) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      hold_cnt     = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t ns: result expected none actual %0d %0d %0d %0d", $time,
                 res_bus.out_red, res_bus.out_green, res_bus.out_blue, res_bus.frame_end);
        mismatch_cnt++;
      end else begin
        check_field("red", expected_pixels[0].pix.red, res_bus.out_red);
        check_field("green", expected_pixels[0].pix.green, res_bus.out_green);
        check_field("blue", expected_pixels[0].pix.blue, res_bus.out_blue);
        check_field("frame_end", PIX_W'(expected_pixels[0].frame_end),
                    PIX_W'(res_bus.frame_end));
        void'(expected_pixels.pop_front());
      end
    end
  end

  initial begin
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n                <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.downscale_on <= 1'b1;
    pix_bus.valid        <= 1'b0;
    pix_bus.in_red       <= '0;
    pix_bus.in_green     <= '0;
    pix_bus.in_blue      <= '0;
    pix_bus.frame_start  <= 1'b0;
    ds_mode = 1'b1;
    clear_position();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 76;
    test_reset_default();
    test_passthrough_extremes();
    test_block_extremes();
    test_mode_switch();

    send_idle_pct = 76;
    recv_idle_pct = 23;
    test_downscale_random(4);
    test_mode_switch();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_drain_pause();
    test_downscale_random(4);

    wait_idle();
    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
